/* src/fhd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhd_pkg
// Shared types and constants for the frame header deframer.
// ----------------------------------------------------------------------------
package fhd_pkg;

  localparam int unsigned HDR_LEN = 15;
  localparam int unsigned POS_W   = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // header byte offsets
  localparam logic [3:0] OFS_CTRL_LO = 4'd0;
  localparam logic [3:0] OFS_CTRL_HI = 4'd1;
  localparam logic [3:0] OFS_SEQ     = 4'd2;
  localparam logic [3:0] OFS_PAN_LO  = 4'd3;
  localparam logic [3:0] OFS_PAN_HI  = 4'd4;
  localparam logic [3:0] OFS_DST_LO  = 4'd5;
  localparam logic [3:0] OFS_DST_HI  = 4'd6;
  localparam logic [3:0] OFS_SRC_LO  = 4'd7;
  localparam logic [3:0] OFS_SRC_HI  = 4'd8;
  localparam logic [3:0] OFS_VER     = 4'd9;
  localparam logic [3:0] OFS_FUNC    = 4'd10;
  localparam logic [3:0] OFS_FLAGS   = 4'd11;
  localparam logic [3:0] OFS_EXT_LEN = 4'd12;
  localparam logic [3:0] OFS_PAY_LO  = 4'd13;
  localparam logic [3:0] OFS_PAY_HI  = 4'd14;

  // configuration register indexes
  localparam logic [1:0] REG_EXP_VERSION = 2'd0;
  localparam logic [1:0] REG_MAX_EXT_LEN = 2'd1;
  localparam logic [1:0] REG_MAX_PAY_LEN = 2'd2;

  localparam logic [7:0]  EXP_VERSION_RST = 8'd1;
  localparam logic [7:0]  MAX_EXT_LEN_RST = 8'hFF;
  localparam logic [15:0] MAX_PAY_LEN_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_EXT     = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_SHORT    = 3'd1,
    STAT_VERSION  = 3'd2,
    STAT_EXT_LONG = 3'd3,
    STAT_PAY_LONG = 3'd4,
    STAT_TRUNC    = 3'd5
  } status_t;

  typedef struct packed {
    logic [15:0] frame_control;
    logic [7:0]  sequence_res;
    logic [15:0] pan_ident;
    logic [15:0] dest_address;
    logic [15:0] source_address;
    logic [7:0]  function_code;
    logic [7:0]  header_flags;
    logic [7:0]  extension_length;
    logic [15:0] payload_length;
  } header_t;

  // one queue entry: the results caused by one input byte
  typedef struct packed {
    logic    has_main;
    kind_t   main_kind;
    status_t main_status;
    logic [7:0] data_value;
    header_t hdr;
    logic    has_end;
    status_t end_status;
  } entry_t;

endpackage : fhd_pkg
`default_nettype wire

/* src/fhd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhd_front
// Byte counter, header capture, header checks and byte classification.
// Produces one queue entry for every byte that causes a result.
// ----------------------------------------------------------------------------
module fhd_front (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              cfg_write,
  input  wire  logic [1:0]        cfg_index,
  input  wire  logic [15:0]       cfg_data,
  input  wire  logic              accept,
  input  wire  logic [7:0]        rx_byte,
  input  wire  logic              final_byte,
  output       logic              push,
  output       fhd_pkg::entry_t   push_entry
);
  import fhd_pkg::*;

  logic [7:0]  expected_version;
  logic [7:0]  max_extension_length;
  logic [15:0] max_payload_length;

  logic [POS_W-1:0] byte_position;
  status_t          error_code;

  logic [15:0] captured_control;
  logic [7:0]  captured_sequence;
  logic [15:0] captured_pan;
  logic [15:0] captured_dest;
  logic [15:0] captured_source;
  logic [7:0]  captured_version;
  logic [7:0]  captured_function;
  logic [7:0]  captured_flags;
  logic [7:0]  captured_ext_len;
  logic [15:0] captured_pay_len;

  logic             in_header;
  logic             hdr_last;
  logic [15:0]      pay_len_now;
  status_t          hdr_err;
  status_t          err_now;
  logic [POS_W-1:0] ext_end;
  logic [POS_W-1:0] data_end;
  logic [POS_W-1:0] pos_inc;
  entry_t           entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version     <= EXP_VERSION_RST;
      max_extension_length <= MAX_EXT_LEN_RST;
      max_payload_length   <= MAX_PAY_LEN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EXP_VERSION: expected_version     <= cfg_data[7:0];
        REG_MAX_EXT_LEN: max_extension_length <= cfg_data[7:0];
        REG_MAX_PAY_LEN: max_payload_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_header   = (byte_position < POS_W'(HDR_LEN));
  assign hdr_last    = (byte_position == POS_W'(HDR_LEN - 1));
  // byte 14 completes the payload length in the same cycle as the checks
  assign pay_len_now = hdr_last ? {rx_byte, captured_pay_len[7:0]} : captured_pay_len;

  always_comb begin
    if (captured_version != expected_version) begin
      hdr_err = STAT_VERSION;
    end else if (captured_ext_len > max_extension_length) begin
      hdr_err = STAT_EXT_LONG;
    end else if (pay_len_now > max_payload_length) begin
      hdr_err = STAT_PAY_LONG;
    end else begin
      hdr_err = STAT_OK;
    end
  end

  assign err_now  = hdr_last ? hdr_err : error_code;
  assign ext_end  = POS_W'(HDR_LEN) + POS_W'(captured_ext_len);
  assign data_end = ext_end + POS_W'(pay_len_now);
  assign pos_inc  = (byte_position == POS_MAX) ? byte_position : byte_position + 1'b1;

  always_comb begin
    entry                       = '0;
    entry.hdr.frame_control     = captured_control;
    entry.hdr.sequence_res      = captured_sequence;
    entry.hdr.pan_ident         = captured_pan;
    entry.hdr.dest_address      = captured_dest;
    entry.hdr.source_address    = captured_source;
    entry.hdr.function_code     = captured_function;
    entry.hdr.header_flags      = captured_flags;
    entry.hdr.extension_length  = captured_ext_len;
    entry.hdr.payload_length    = pay_len_now;
    entry.data_value            = rx_byte;
    entry.main_kind             = KIND_HEADER;
    entry.main_status           = hdr_err;
    if (in_header) begin
      entry.has_main = hdr_last;
    end else if (error_code == STAT_OK) begin
      if (byte_position < ext_end) begin
        entry.has_main  = 1'b1;
        entry.main_kind = KIND_EXT;
      end else if (byte_position < data_end) begin
        entry.has_main  = 1'b1;
        entry.main_kind = KIND_PAYLOAD;
      end
    end
    entry.has_end = final_byte;
    if (pos_inc < POS_W'(HDR_LEN)) begin
      entry.end_status = STAT_SHORT;
    end else if (err_now != STAT_OK) begin
      entry.end_status = err_now;
    end else if (pos_inc < data_end) begin
      entry.end_status = STAT_TRUNC;
    end else begin
      entry.end_status = STAT_OK;
    end
  end

  assign push       = accept && (entry.has_main || entry.has_end);
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      error_code    <= STAT_OK;
    end else if (accept) begin
      if (final_byte) begin
        byte_position <= '0;
        error_code    <= STAT_OK;
      end else begin
        byte_position <= pos_inc;
        if (hdr_last) begin
          error_code <= hdr_err;
        end
      end
    end
  end

  // every header field is rewritten before it is used, so no reset here
  always_ff @(posedge clk) begin
    if (accept && in_header) begin
      case (byte_position[3:0])
        OFS_CTRL_LO: captured_control[7:0]  <= rx_byte;
        OFS_CTRL_HI: captured_control[15:8] <= rx_byte;
        OFS_SEQ:     captured_sequence      <= rx_byte;
        OFS_PAN_LO:  captured_pan[7:0]      <= rx_byte;
        OFS_PAN_HI:  captured_pan[15:8]     <= rx_byte;
        OFS_DST_LO:  captured_dest[7:0]     <= rx_byte;
        OFS_DST_HI:  captured_dest[15:8]    <= rx_byte;
        OFS_SRC_LO:  captured_source[7:0]   <= rx_byte;
        OFS_SRC_HI:  captured_source[15:8]  <= rx_byte;
        OFS_VER:     captured_version       <= rx_byte;
        OFS_FUNC:    captured_function      <= rx_byte;
        OFS_FLAGS:   captured_flags         <= rx_byte;
        OFS_EXT_LEN: captured_ext_len       <= rx_byte;
        OFS_PAY_LO:  captured_pay_len[7:0]  <= rx_byte;
        OFS_PAY_HI:  captured_pay_len[15:8] <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule : fhd_front
`default_nettype wire

/* src/fhd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhd_queue
// Short FIFO of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module fhd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire  logic            clk,
  input  wire  logic            rst,
  input  wire  logic            push,
  input  wire  fhd_pkg::entry_t push_entry,
  input  wire  logic            pop,
  output       fhd_pkg::entry_t head,
  output       logic            empty,
  output       logic            full
);
  import fhd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_FULL);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count out of range");

endmodule : fhd_queue
`default_nettype wire

/* src/fhd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fhd_back
// Turns queue entries into result transfers through an output register.
// An entry holding a data/header result and an end result takes two transfers.
// ----------------------------------------------------------------------------
module fhd_back (
  input  wire  logic            clk,
  input  wire  logic            rst,
  input  wire  fhd_pkg::entry_t head,
  input  wire  logic            empty,
  output       logic            pop,
  output       logic            out_valid,
  input  wire  logic            out_stall,
  output       logic [1:0]      result_kind,
  output       logic [15:0]     frame_control,
  output       logic [7:0]      sequence_res,
  output       logic [15:0]     pan_ident,
  output       logic [15:0]     dest_address,
  output       logic [15:0]     source_address,
  output       logic [7:0]      function_code,
  output       logic [7:0]      header_flags,
  output       logic [7:0]      extension_length,
  output       logic [15:0]     payload_length,
  output       logic [7:0]      data_value,
  output       logic [2:0]      status
);
  import fhd_pkg::*;

  logic    load;
  logic    emit_main;
  logic    split;
  logic    phase;       // main result of the head entry already sent
  header_t hdr_out;

  assign load      = !out_valid || !out_stall;
  assign emit_main = head.has_main && !phase;
  assign split     = emit_main && head.has_end;
  assign pop       = load && !empty && !split;

  assign hdr_out = (emit_main && head.main_kind == KIND_HEADER) ? head.hdr : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        phase <= split;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      frame_control    <= hdr_out.frame_control;
      sequence_res     <= hdr_out.sequence_res;
      pan_ident        <= hdr_out.pan_ident;
      dest_address     <= hdr_out.dest_address;
      source_address   <= hdr_out.source_address;
      function_code    <= hdr_out.function_code;
      header_flags     <= hdr_out.header_flags;
      extension_length <= hdr_out.extension_length;
      payload_length   <= hdr_out.payload_length;
      if (emit_main) begin
        result_kind <= head.main_kind;
        data_value  <= (head.main_kind == KIND_HEADER) ? 8'd0 : head.data_value;
        status      <= (head.main_kind == KIND_HEADER) ? head.main_status : STAT_OK;
      end else begin
        result_kind <= KIND_END;
        data_value  <= 8'd0;
        status      <= head.end_status;
      end
    end
  end

endmodule : fhd_back
`default_nettype wire

/* src/frame_header_deframer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// frame_header_deframer_unit
// Byte-wide frame deframer: captures the 15-byte header, checks it and tags
// the extension and payload bytes that follow.
//
// Input channel: rx_byte/final_byte, transfer when in_valid && !in_stall.
// Output channel: one result per transfer when out_valid && !out_stall.
// Header result on byte 15; if the header passes, one tagged result per
// extension/payload byte; an end result with status on the last byte. Surplus
// bytes give none. A byte's first result goes through the queue to the output
// register. Throughput: one byte per cycle while in_stall is low; a last byte
// that also carries a header or data result takes two output transfers.
// Results wait in a QUEUE_DEPTH-entry queue; in_stall rises when it is full,
// so a stalled receiver holds the input side after that many entries.
// Reset (rst, synchronous) restores the register defaults (version 1,
// limits 255 and 65535), empties the queue and starts a new frame.
// Configuration: cfg_write/cfg_index/cfg_data, written while idle.
// ----------------------------------------------------------------------------
module frame_header_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        cfg_write,
  input  wire  logic [1:0]  cfg_index,
  input  wire  logic [15:0] cfg_data,
  input  wire  logic        in_valid,
  output       logic        in_stall,
  input  wire  logic [7:0]  rx_byte,
  input  wire  logic        final_byte,
  output       logic        out_valid,
  input  wire  logic        out_stall,
  output       logic [1:0]  result_kind,
  output       logic [15:0] frame_control,
  output       logic [7:0]  sequence_res,
  output       logic [15:0] pan_ident,
  output       logic [15:0] dest_address,
  output       logic [15:0] source_address,
  output       logic [7:0]  function_code,
  output       logic [7:0]  header_flags,
  output       logic [7:0]  extension_length,
  output       logic [15:0] payload_length,
  output       logic [7:0]  data_value,
  output       logic [2:0]  status
);
  import fhd_pkg::*;

  logic   accept;
  logic   push;
  logic   pop;
  logic   empty;
  logic   full;
  entry_t push_entry;
  entry_t head;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  fhd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .final_byte (final_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  fhd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  fhd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .frame_control    (frame_control),
    .sequence_res     (sequence_res),
    .pan_ident        (pan_ident),
    .dest_address     (dest_address),
    .source_address   (source_address),
    .function_code    (function_code),
    .header_flags     (header_flags),
    .extension_length (extension_length),
    .payload_length   (payload_length),
    .data_value       (data_value),
    .status           (status)
  );

endmodule : frame_header_deframer_unit
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_header_deframer_unit. A table of directed
// frames covers the header checks, short and truncated frames, surplus bytes
// and extreme field values. Random frames under several
// limit settings follow. Every transfer on the output is compared with the
// result computed by an in-bench deframer model. Gaps and output stalls come
// in random bursts.
// ----------------------------------------------------------------------------
module testbench;

  import fhd_pkg::*;

  localparam longint RUN_LIMIT_NS = 15_000_000;
  localparam int     NUM_ROWS     = 18;

  // fill codes for the non-checked header bytes and the data bytes
  localparam logic [1:0] FILL_ZERO = 2'd0;
  localparam logic [1:0] FILL_ONES = 2'd1;
  localparam logic [1:0] FILL_RAND = 2'd2;

  typedef struct packed {
    kind_t       kind;
    header_t     hdr;
    logic [7:0]  data;
    status_t     stat;
  } deframe_result_t;

  typedef struct packed {
    logic [17:0] len;
    logic [7:0]  cfg_ver;
    logic [7:0]  cfg_ext;
    logic [15:0] cfg_pay;
    logic [7:0]  ver;
    logic [7:0]  ext;
    logic [15:0] pay;
    logic [1:0]  fill;
    logic        chk;      // end status typed in the row
    status_t     end_stat;
  } frame_row_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        cfg_write  = 1'b0;
  logic [1:0]  cfg_index  = REG_EXP_VERSION;
  logic [15:0] cfg_data   = 16'h0000;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte    = 8'h00;
  logic        final_byte = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  result_kind;
  logic [15:0] frame_control;
  logic [7:0]  sequence_res;
  logic [15:0] pan_ident;
  logic [15:0] dest_address;
  logic [15:0] source_address;
  logic [7:0]  function_code;
  logic [7:0]  header_flags;
  logic [7:0]  extension_length;
  logic [15:0] payload_length;
  logic [7:0]  data_value;
  logic [2:0]  status;

  // deframer model state and limits
  logic [7:0]  lim_ver   = EXP_VERSION_RST;
  logic [7:0]  lim_ext   = MAX_EXT_LEN_RST;
  logic [15:0] lim_pay   = MAX_PAY_LEN_RST;
  logic [16:0] frame_pos = '0;
  header_t     hdr_cap   = '0;
  logic [7:0]  ver_cap   = '0;
  status_t     frame_err = STAT_OK;

  deframe_result_t pending_results [$];
  frame_row_t      frame_table [NUM_ROWS];

  int          mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned gap_odds       = 0;
  int unsigned stall_odds     = 0;

  frame_header_deframer_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .final_byte       (final_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .frame_control    (frame_control),
    .sequence_res     (sequence_res),
    .pan_ident        (pan_ident),
    .dest_address     (dest_address),
    .source_address   (source_address),
    .function_code    (function_code),
    .header_flags     (header_flags),
    .extension_length (extension_length),
    .payload_length   (payload_length),
    .data_value       (data_value),
    .status           (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Advance the model by one byte and queue the results it causes.
  task automatic deframe_byte(input logic [7:0] b, input logic last);
    deframe_result_t r;
    int unsigned     off;
    if (frame_pos < HDR_LEN) begin
      case (frame_pos[3:0])
        OFS_CTRL_LO: hdr_cap.frame_control[7:0]   = b;
        OFS_CTRL_HI: hdr_cap.frame_control[15:8]  = b;
        OFS_SEQ:     hdr_cap.sequence_res         = b;
        OFS_PAN_LO:  hdr_cap.pan_ident[7:0]       = b;
        OFS_PAN_HI:  hdr_cap.pan_ident[15:8]      = b;
        OFS_DST_LO:  hdr_cap.dest_address[7:0]    = b;
        OFS_DST_HI:  hdr_cap.dest_address[15:8]   = b;
        OFS_SRC_LO:  hdr_cap.source_address[7:0]  = b;
        OFS_SRC_HI:  hdr_cap.source_address[15:8] = b;
        OFS_VER:     ver_cap                      = b;
        OFS_FUNC:    hdr_cap.function_code        = b;
        OFS_FLAGS:   hdr_cap.header_flags         = b;
        OFS_EXT_LEN: hdr_cap.extension_length     = b;
        OFS_PAY_LO:  hdr_cap.payload_length[7:0]  = b;
        default:     hdr_cap.payload_length[15:8] = b;
      endcase
      if (frame_pos == HDR_LEN - 1) begin
        // version first, then extension, then payload
        if (ver_cap != lim_ver) frame_err = STAT_VERSION;
        else if (hdr_cap.extension_length > lim_ext) frame_err = STAT_EXT_LONG;
        else if (hdr_cap.payload_length > lim_pay) frame_err = STAT_PAY_LONG;
        else frame_err = STAT_OK;
        r = '0;
        r.kind = KIND_HEADER;
        r.hdr  = hdr_cap;
        r.stat = frame_err;
        pending_results.push_back(r);
      end
    end else if (frame_err == STAT_OK) begin
      off = frame_pos - HDR_LEN;
      r = '0;
      r.data = b;
      if (off < hdr_cap.extension_length) begin
        r.kind = KIND_EXT;
        pending_results.push_back(r);
      end else if (off < hdr_cap.extension_length + hdr_cap.payload_length) begin
        r.kind = KIND_PAYLOAD;
        pending_results.push_back(r);
      end
    end
    if (frame_pos != POS_MAX) frame_pos++;
    if (last) begin
      r = '0;
      r.kind = KIND_END;
      if (frame_pos < HDR_LEN) r.stat = STAT_SHORT;
      else if (frame_err != STAT_OK) r.stat = frame_err;
      else if (frame_pos < HDR_LEN + hdr_cap.extension_length + hdr_cap.payload_length)
        r.stat = STAT_TRUNC;
      else r.stat = STAT_OK;
      pending_results.push_back(r);
      frame_pos = '0;
      hdr_cap   = '0;
      ver_cap   = '0;
      frame_err = STAT_OK;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    rx_byte    <= b;
    final_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    deframe_byte(b, last);
  endtask

  task automatic send_frame(input int unsigned len, input logic [7:0] ver,
                            input logic [7:0] ext, input logic [15:0] pay,
                            input logic [1:0] fill, input logic chk,
                            input status_t end_stat);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      if (i == OFS_VER) b = ver;
      else if (i == OFS_EXT_LEN) b = ext;
      else if (i == OFS_PAY_LO) b = pay[7:0];
      else if (i == OFS_PAY_HI) b = pay[15:8];
      send_byte(b, i == len - 1);
    end
    // typed end status replaces the computed one
    if (chk) pending_results[pending_results.size() - 1].stat = end_stat;
  endtask

  // Stop sending and wait until the block has nothing left to deliver.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_limits(input logic [7:0] ver, input logic [7:0] ext,
                             input logic [15:0] pay);
    cfg_write <= 1'b1;
    cfg_index <= REG_EXP_VERSION;
    cfg_data  <= {8'($urandom), ver};
    @(posedge clk);
    cfg_index <= REG_MAX_EXT_LEN;
    cfg_data  <= {8'($urandom), ext};
    @(posedge clk);
    cfg_index <= REG_MAX_PAY_LEN;
    cfg_data  <= pay;
    @(posedge clk);
    cfg_write <= 1'b0;
    lim_ver = ver;
    lim_ext = ext;
    lim_pay = pay;
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned need;
    int unsigned len;
    int unsigned sel;
    logic [7:0]  ver;
    logic [7:0]  ext;
    logic [15:0] pay;
    pick = $urandom_range(0, 99);
    ver  = ($urandom_range(0, 6) == 0) ? 8'($urandom) : lim_ver;
    sel  = $urandom_range(0, 9);
    if (sel < 7) ext = 8'($urandom_range(0, (lim_ext < 6) ? lim_ext : 6));
    else if (sel == 7) ext = lim_ext + 8'd1;
    else ext = 8'($urandom);
    sel  = $urandom_range(0, 9);
    if (sel < 7) pay = 16'($urandom_range(0, (lim_pay < 12) ? lim_pay : 12));
    else if (sel == 7) pay = lim_pay + 16'd1;
    else pay = 16'($urandom);
    need = HDR_LEN + ext + pay;
    if (pick < 8) begin
      // noise: random header and length
      ver = 8'($urandom);
      len = $urandom_range(1, 20);
    end else if (pick < 16) len = $urandom_range(1, HDR_LEN - 1);
    else if (pick < 28 && need > HDR_LEN) len = $urandom_range(HDR_LEN, need - 1);
    else if (pick < 40) len = need + $urandom_range(1, 4);
    else len = need;
    if (len > 80) len = $urandom_range(HDR_LEN, 80);
    send_frame(len, ver, ext, pay, FILL_RAND, 1'b0, STAT_OK);
  endtask

  // receiver backpressure
  initial begin : rx_backpressure
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    deframe_result_t got;
    deframe_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.kind                    = kind_t'(result_kind);
      got.hdr.frame_control       = frame_control;
      got.hdr.sequence_res        = sequence_res;
      got.hdr.pan_ident           = pan_ident;
      got.hdr.dest_address        = dest_address;
      got.hdr.source_address      = source_address;
      got.hdr.function_code       = function_code;
      got.hdr.header_flags        = header_flags;
      got.hdr.extension_length    = extension_length;
      got.hdr.payload_length      = payload_length;
      got.data                    = data_value;
      got.stat                    = status_t'(status);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d status %0d",
                                  got.kind, got.stat));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "kind %0d/%0d status %0d/%0d data %02h/%02h hdr %h/%h (got/want)",
            got.kind, want.kind, got.stat, want.stat, got.data, want.data,
            got.hdr, want.hdr));
      end
    end
  end

  initial begin : stimulus
    frame_row_t  row;
    int unsigned phase_start;
    int unsigned drain_wait;
    frame_table = '{
      // len      cfg ver/ext/pay           frame ver/ext/pay       fill  typed end
      '{18'd1,      8'd1,   8'd255, 16'hFFFF, 8'd1,   8'd0,   16'd0,    FILL_ONES,
        1'b1, STAT_SHORT},
      '{18'd14,     8'd1,   8'd255, 16'hFFFF, 8'd1,   8'd0,   16'd0,    FILL_ZERO,
        1'b1, STAT_SHORT},
      '{18'd15,     8'd1,   8'd255, 16'hFFFF, 8'd1,   8'd0,   16'd0,    FILL_ZERO,
        1'b1, STAT_OK},
      '{18'd15,     8'd1,   8'd255, 16'hFFFF, 8'd0,   8'd0,   16'd0,    FILL_ONES,
        1'b1, STAT_VERSION},
      '{18'd18,     8'd1,   8'd255, 16'hFFFF, 8'd1,   8'd1,   16'd2,    FILL_RAND,
        1'b0, STAT_OK},
      '{18'd16,     8'd1,   8'd255, 16'hFFFF, 8'd1,   8'd1,   16'd2,    FILL_RAND,
        1'b1, STAT_TRUNC},
      '{18'd22,     8'd1,   8'd255, 16'hFFFF, 8'd1,   8'd2,   16'd1,    FILL_RAND,
        1'b0, STAT_OK},
      '{18'd20,     8'd1,   8'd255, 16'hFFFF, 8'd1,   8'd255, 16'hFFFF, FILL_ONES,
        1'b1, STAT_TRUNC},
      '{18'd17,     8'd1,   8'd255, 16'hFFFF, 8'd2,   8'd0,   16'd1,    FILL_RAND,
        1'b1, STAT_VERSION},
      // short payload followed by a long run of surplus bytes
      '{18'd40,     8'd1,   8'd255, 16'hFFFF, 8'd1,   8'd0,   16'd3,    FILL_RAND,
        1'b1, STAT_OK},
      '{18'd16,     8'd1,   8'd4,   16'd8,    8'd1,   8'd5,   16'd0,    FILL_RAND,
        1'b1, STAT_EXT_LONG},
      '{18'd15,     8'd1,   8'd4,   16'd8,    8'd1,   8'd4,   16'd9,    FILL_RAND,
        1'b1, STAT_PAY_LONG},
      '{18'd15,     8'd1,   8'd4,   16'd8,    8'd7,   8'd5,   16'd9,    FILL_RAND,
        1'b1, STAT_VERSION},
      '{18'd15,     8'd1,   8'd4,   16'd8,    8'd1,   8'd5,   16'd9,    FILL_RAND,
        1'b1, STAT_EXT_LONG},
      '{18'd16,     8'd0,   8'd0,   16'd0,    8'd0,   8'd0,   16'd0,    FILL_ONES,
        1'b1, STAT_OK},
      '{18'd15,     8'd0,   8'd0,   16'd0,    8'd0,   8'd0,   16'd1,    FILL_ZERO,
        1'b1, STAT_PAY_LONG},
      '{18'd15,     8'd255, 8'd255, 16'hFFFF, 8'd255, 8'd0,   16'hFFFF, FILL_ONES,
        1'b1, STAT_TRUNC},
      '{18'd15,     8'd255, 8'd0,   16'd0,    8'd255, 8'd1,   16'd0,    FILL_RAND,
        1'b1, STAT_EXT_LONG}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed frames, first ones on the reset limits
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = frame_table[r];
      if (row.cfg_ver != lim_ver || row.cfg_ext != lim_ext || row.cfg_pay != lim_pay) begin
        settle();
        load_limits(row.cfg_ver, row.cfg_ext, row.cfg_pay);
      end
      gap_odds   = (row.len > 1000) ? 0 : 6;
      stall_odds = 5;
      send_frame(row.len, row.ver, row.ext, row.pay, row.fill, row.chk, row.end_stat);
    end

    // random frames, one limit setting per phase
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: load_limits(8'd1, 8'd6, 16'd12);
        1: load_limits(8'd0, 8'd0, 16'd0);
        2: load_limits(8'd255, 8'd255, 16'hFFFF);
        5: load_limits(8'($urandom), 8'd3, 16'd5);
        default: load_limits(8'($urandom),
                             ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 10)),
                             ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 20)));
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 270) begin
        if (phase == 5) begin
          gap_odds   = 0;
          stall_odds = 0;
        end else begin
          gap_odds   = $urandom_range(0, 3) * 4;
          stall_odds = $urandom_range(0, 3) * 4;
        end
        random_frame();
      end
    end

    in_valid <= 1'b0;
    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < 4000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule : testbench

/* frame_header_deframer_unit.f */
src/fhd_pkg.sv
src/fhd_front.sv
src/fhd_queue.sv
src/fhd_back.sv
src/frame_header_deframer_unit.sv
tb/testbench.sv
